>>> rtl/core/spe_pkg.sv
package spe_pkg;

  localparam int MAX_POINTS_DEF = 16;
  localparam int FRAC_BITS_DEF  = 16;

  // Multiplier A operand: wide enough for the Catmull-Rom cubic coefficient
  localparam int MUL_AW = 36;

  localparam int CFG_IW = 1;
  localparam int CFG_DW = 5;

  localparam logic [CFG_IW-1:0] REG_CURVE_KIND  = 1'd0;
  localparam logic [CFG_IW-1:0] REG_POINT_COUNT = 1'd1;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_EVAL = 1'b1;

  localparam logic [1:0] KIND_LINEAR  = 2'd0;
  localparam logic [1:0] KIND_BEZIER  = 2'd1;
  localparam logic [1:0] KIND_CATMULL = 2'd2;

  typedef struct packed {
    logic               op;
    logic [3:0]         slot;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] param_t;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
  } out_item_t;

  // One stored point, index 0 is x, 1 is y, 2 is z
  typedef logic [2:0][31:0] pt_word_t;

  typedef enum logic [5:0] {
    ST_IDLE,
    ST_SEG,
    ST_SEGW,
    ST_FETCH,
    ST_FETCHW,
    ST_LIN_P,
    ST_LIN_Q,
    ST_LIN_QW,
    ST_LIN_MUL,
    ST_LIN_ADD,
    ST_CL_A,
    ST_CL_B,
    ST_CL_BW,
    ST_CL_SQ,
    ST_CL_SQW,
    ST_CL_CMP,
    ST_CR_T2,
    ST_CR_T2W,
    ST_CR_T3,
    ST_CR_T3W,
    ST_CR_RD,
    ST_CR_CAP,
    ST_CR_COEF,
    ST_CR_M1,
    ST_CR_M2,
    ST_CR_M3,
    ST_CR_ACC,
    ST_CR_RES,
    ST_BZ_R0,
    ST_BZ_R1,
    ST_BZ_MUL,
    ST_BZ_WR,
    ST_DONE
  } spe_state_t;

endpackage

>>> rtl/core/spline_point_evaluator.sv
// Channel  Direction  Handshake              Payload
// in_      input      in_valid / in_ready    in_data (op, slot, pos_x/y/z, param_t)
// out_     output     out_valid / out_ready  out_data (out_x, out_y, out_z)
// cfg_     input      cfg_we                 cfg_index, cfg_wdata (curve_kind, point_count)
//
// A load item yields nothing and leaves the sequencer idle. An evaluate item runs
// on one shared multiplier under a sequencer; with no points it gives zero, with one
// point or at the end of a linear or Catmull-Rom curve it returns the stored point,
// Catmull-Rom adds a closed path test, and Bezier lerps pass through the working
// buffer. in_ready is high only while the sequencer is idle; a finished result
// waits in the output register, so new items are taken while out_ready is low.
// Reset (rst_n, synchronous, active low) clears the sequencer, output valid and
// the configuration registers; the point store is undefined until loaded.
module spline_point_evaluator #(
  parameter int MAX_POINTS = spe_pkg::MAX_POINTS_DEF,
  parameter int FRAC_BITS  = spe_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  spe_pkg::in_item_t             in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output spe_pkg::out_item_t            out_data,
  input  logic                          cfg_we,
  input  logic [spe_pkg::CFG_IW-1:0]    cfg_index,
  input  logic [spe_pkg::CFG_DW-1:0]    cfg_wdata
);
  import spe_pkg::*;

  localparam int AW   = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int NW   = $clog2(MAX_POINTS + 1);
  localparam int KW   = NW + 1;
  localparam int TW   = FRAC_BITS + 1;
  localparam int MBW  = FRAC_BITS + 2;
  localparam int PW   = MUL_AW + MBW;
  localparam int ACCW = FRAC_BITS + 40;

  localparam logic [TW-1:0] T_ONE = {1'b1, {FRAC_BITS{1'b0}}};
  localparam longint EPS_L  = ((longint'(1) << FRAC_BITS) + 50) / 100;
  localparam longint EPS2_L = EPS_L * EPS_L;
  localparam logic [32:0] EPS_D = 33'(EPS_L);
  localparam logic signed [ACCW-1:0] EPS2_A = ACCW'(EPS2_L);
  localparam logic signed [ACCW-1:0] HALF_A = ACCW'(longint'(1) << (FRAC_BITS - 1));
  localparam logic signed [ACCW-1:0] ONE_A  = ACCW'(longint'(1) << FRAC_BITS);
  localparam logic signed [ACCW-1:0] SAT_HI = ACCW'(longint'(32'h7fff_ffff));
  localparam logic signed [ACCW-1:0] SAT_LO = -SAT_HI - ACCW'(1);

  // Round a lerp product and add it to its start point; stays in range
  function automatic logic [31:0] lerp_out(input logic signed [31:0] p,
                                           input logic signed [PW-1:0] prod);
    logic signed [ACCW-1:0] v;
    v = ACCW'(p) + ((ACCW'(prod) + HALF_A) >>> FRAC_BITS);
    return v[31:0];
  endfunction

  function automatic logic [31:0] sat32(input logic signed [ACCW-1:0] v);
    logic signed [ACCW-1:0] c;
    c = v;
    if (v > SAT_HI) c = SAT_HI;
    if (v < SAT_LO) c = SAT_LO;
    return c[31:0];
  endfunction

  // Control state
  spe_state_t        state_r, state_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [1:0]        kind_r;
  logic [4:0]        count_r;

  // Working registers
  logic [NW-1:0]     n_r, n_nxt;
  logic [TW-1:0]     t_r, t_nxt;
  logic [FRAC_BITS-1:0] f_r, f_nxt;
  logic [NW-1:0]     base_r, base_nxt;
  logic [AW-1:0]     fa_r, fa_nxt;
  logic              closed_r, closed_nxt;
  logic [1:0]        axis_r, axis_nxt;
  logic [1:0]        j_r, j_nxt;
  logic [NW-1:0]     lvl_r, lvl_nxt;
  logic [NW-1:0]     idx_r, idx_nxt;
  logic              first_r, first_nxt;
  logic signed [31:0] prev_r, prev_nxt;
  logic signed [31:0] cur_r, cur_nxt;
  pt_word_t          wa_r, wa_nxt;
  pt_word_t          pw_r [4];
  pt_word_t          pw_nxt [4];
  logic [32:0]       d_r [3];
  logic [32:0]       d_nxt [3];
  logic [TW-1:0]     t2_r, t2_nxt;
  logic [TW-1:0]     t3_r, t3_nxt;
  logic signed [MUL_AW-1:0] c1_r, c1_nxt;
  logic signed [MUL_AW-1:0] c2_r, c2_nxt;
  logic signed [MUL_AW-1:0] c3_r, c3_nxt;
  logic signed [ACCW-1:0]   acc_r, acc_nxt;
  pt_word_t          res_r, res_nxt;
  out_item_t         out_r;

  // Shared multiplier, product registered
  logic signed [MUL_AW-1:0] mul_a;
  logic signed [MBW-1:0]    mul_b;
  logic signed [PW-1:0]     prod_r;

  // Point store and Bezier working buffer
  pt_word_t          pmem [MAX_POINTS];
  logic signed [31:0] wmem [MAX_POINTS];
  pt_word_t          rdata_r;
  logic signed [31:0] wdata_r;
  logic [AW-1:0]     rd_addr;
  logic              pm_we;
  logic              wm_we;
  logic [AW-1:0]     wm_addr;
  logic signed [31:0] wm_data;
  logic              out_load;

  always_comb begin
    logic [NW-1:0]  n_in;
    logic [NW-1:0]  bs;
    logic [KW-1:0]  k;
    logic signed [32:0] diff;
    logic           near_pt;
    logic signed [MUL_AW-1:0] p0, p1, p2, p3;
    logic signed [31:0] src;
    logic [31:0]    w;

    state_nxt     = state_r;
    n_nxt         = n_r;
    t_nxt         = t_r;
    f_nxt         = f_r;
    base_nxt      = base_r;
    fa_nxt        = fa_r;
    closed_nxt    = closed_r;
    axis_nxt      = axis_r;
    j_nxt         = j_r;
    lvl_nxt       = lvl_r;
    idx_nxt       = idx_r;
    first_nxt     = first_r;
    prev_nxt      = prev_r;
    cur_nxt       = cur_r;
    wa_nxt        = wa_r;
    pw_nxt        = pw_r;
    d_nxt         = d_r;
    t2_nxt        = t2_r;
    t3_nxt        = t3_r;
    c1_nxt        = c1_r;
    c2_nxt        = c2_r;
    c3_nxt        = c3_r;
    acc_nxt       = acc_r;
    res_nxt       = res_r;
    mul_a         = '0;
    mul_b         = '0;
    rd_addr       = '0;
    pm_we         = 1'b0;
    wm_we         = 1'b0;
    wm_addr       = AW'(idx_r);
    wm_data       = '0;
    in_ready      = 1'b0;
    out_load      = 1'b0;
    n_in          = (32'(count_r) > MAX_POINTS) ? NW'(MAX_POINTS) : NW'(count_r);
    bs            = prod_r[FRAC_BITS +: NW];
    k             = KW'(base_r) + KW'(j_r);
    diff          = '0;
    near_pt       = 1'b1;
    p0            = $signed(MUL_AW'($signed(pw_r[0][axis_r])));
    p1            = $signed(MUL_AW'($signed(pw_r[1][axis_r])));
    p2            = $signed(MUL_AW'($signed(pw_r[2][axis_r])));
    p3            = $signed(MUL_AW'($signed(pw_r[3][axis_r])));
    src           = first_r ? $signed(rdata_r[axis_r]) : wdata_r;
    w             = lerp_out(prev_r, prod_r);
    out_valid_nxt = (out_valid_r && out_ready) ? 1'b0 : out_valid_r;

    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_data.op == OP_LOAD) begin
            // drop loads beyond the store
            pm_we = (32'(in_data.slot) < MAX_POINTS);
          end else begin
            if (in_data.param_t[31]) begin
              t_nxt = '0;
            end else if ($unsigned(in_data.param_t) > 32'(T_ONE)) begin
              t_nxt = T_ONE;
            end else begin
              t_nxt = in_data.param_t[TW-1:0];
            end
            n_nxt = n_in;
            if (n_in == '0) begin
              res_nxt   = '0;
              state_nxt = ST_DONE;
            end else if (n_in == NW'(1)) begin
              fa_nxt    = '0;
              state_nxt = ST_FETCH;
            end else begin
              state_nxt = ST_SEG;
            end
          end
        end
      end
      ST_SEG: begin
        mul_a     = MUL_AW'(n_r - NW'(1));
        mul_b     = MBW'(t_r);
        state_nxt = ST_SEGW;
      end
      ST_SEGW: begin
        f_nxt    = prod_r[FRAC_BITS-1:0];
        base_nxt = (bs > n_r - NW'(2)) ? n_r - NW'(2) : bs;
        fa_nxt   = AW'(n_r - NW'(1));
        case (kind_r)
          KIND_LINEAR: begin
            state_nxt = (t_r == T_ONE) ? ST_FETCH : ST_LIN_P;
          end
          KIND_BEZIER: begin
            lvl_nxt   = n_r;
            idx_nxt   = '0;
            first_nxt = 1'b1;
            axis_nxt  = '0;
            state_nxt = ST_BZ_R0;
          end
          KIND_CATMULL: begin
            state_nxt = (t_r == T_ONE) ? ST_FETCH : ST_CL_A;
          end
          default: begin
            res_nxt   = '0;
            state_nxt = ST_DONE;
          end
        endcase
      end
      ST_FETCH: begin
        rd_addr   = fa_r;
        state_nxt = ST_FETCHW;
      end
      ST_FETCHW: begin
        res_nxt   = rdata_r;
        state_nxt = ST_DONE;
      end
      ST_LIN_P: begin
        rd_addr   = AW'(base_r);
        state_nxt = ST_LIN_Q;
      end
      ST_LIN_Q: begin
        wa_nxt    = rdata_r;
        rd_addr   = AW'(base_r + NW'(1));
        state_nxt = ST_LIN_QW;
      end
      ST_LIN_QW: begin
        pw_nxt[0] = rdata_r;
        axis_nxt  = '0;
        state_nxt = ST_LIN_MUL;
      end
      ST_LIN_MUL: begin
        mul_a     = MUL_AW'($signed(pw_r[0][axis_r])) - MUL_AW'($signed(wa_r[axis_r]));
        mul_b     = MBW'(f_r);
        state_nxt = ST_LIN_ADD;
      end
      ST_LIN_ADD: begin
        res_nxt[axis_r] = lerp_out($signed(wa_r[axis_r]), prod_r);
        axis_nxt        = axis_r + 2'd1;
        state_nxt       = (axis_r == 2'd2) ? ST_DONE : ST_LIN_MUL;
      end
      // closed path test: first against last point
      ST_CL_A: begin
        rd_addr   = '0;
        state_nxt = ST_CL_B;
      end
      ST_CL_B: begin
        wa_nxt    = rdata_r;
        rd_addr   = AW'(n_r - NW'(1));
        state_nxt = ST_CL_BW;
      end
      ST_CL_BW: begin
        for (int a = 0; a < 3; a++) begin
          diff     = 33'($signed(wa_r[a])) - 33'($signed(rdata_r[a]));
          d_nxt[a] = diff[32] ? 33'(-diff) : 33'(diff);
          if (d_nxt[a] >= EPS_D) near_pt = 1'b0;
        end
        acc_nxt    = '0;
        axis_nxt   = '0;
        closed_nxt = 1'b0;
        state_nxt  = near_pt ? ST_CL_SQ : ST_CR_T2;
      end
      ST_CL_SQ: begin
        mul_a     = MUL_AW'(d_r[axis_r]);
        mul_b     = MBW'(d_r[axis_r]);
        state_nxt = ST_CL_SQW;
      end
      ST_CL_SQW: begin
        acc_nxt   = acc_r + ACCW'(prod_r);
        axis_nxt  = axis_r + 2'd1;
        state_nxt = (axis_r == 2'd2) ? ST_CL_CMP : ST_CL_SQ;
      end
      ST_CL_CMP: begin
        closed_nxt = (acc_r < EPS2_A);
        state_nxt  = ST_CR_T2;
      end
      ST_CR_T2: begin
        mul_a     = MUL_AW'(f_r);
        mul_b     = MBW'(f_r);
        state_nxt = ST_CR_T2W;
      end
      ST_CR_T2W: begin
        t2_nxt    = TW'(prod_r >>> FRAC_BITS);
        state_nxt = ST_CR_T3;
      end
      ST_CR_T3: begin
        mul_a     = MUL_AW'(t2_r);
        mul_b     = MBW'(f_r);
        state_nxt = ST_CR_T3W;
      end
      ST_CR_T3W: begin
        t3_nxt    = TW'(prod_r >>> FRAC_BITS);
        j_nxt     = '0;
        state_nxt = ST_CR_RD;
      end
      // fetch the four points of the extended list
      ST_CR_RD: begin
        if (k == '0) begin
          rd_addr = closed_r ? AW'(n_r - NW'(2)) : '0;
        end else if (k == KW'(n_r) + KW'(1)) begin
          rd_addr = closed_r ? AW'(1) : AW'(n_r - NW'(1));
        end else begin
          rd_addr = AW'(k - KW'(1));
        end
        state_nxt = ST_CR_CAP;
      end
      ST_CR_CAP: begin
        pw_nxt[j_r] = rdata_r;
        j_nxt       = j_r + 2'd1;
        axis_nxt    = '0;
        state_nxt   = (j_r == 2'd3) ? ST_CR_COEF : ST_CR_RD;
      end
      ST_CR_COEF: begin
        c1_nxt    = p2 - p0;
        c2_nxt    = (p0 <<< 1) - ((p1 <<< 2) + p1) + (p2 <<< 2) - p3;
        c3_nxt    = ((p1 <<< 1) + p1) - ((p2 <<< 1) + p2) + p3 - p0;
        acc_nxt   = ACCW'(p1) <<< (FRAC_BITS + 1);
        state_nxt = ST_CR_M1;
      end
      ST_CR_M1: begin
        mul_a     = c1_r;
        mul_b     = MBW'(f_r);
        state_nxt = ST_CR_M2;
      end
      ST_CR_M2: begin
        acc_nxt   = acc_r + ACCW'(prod_r);
        mul_a     = c2_r;
        mul_b     = MBW'(t2_r);
        state_nxt = ST_CR_M3;
      end
      ST_CR_M3: begin
        acc_nxt   = acc_r + ACCW'(prod_r);
        mul_a     = c3_r;
        mul_b     = MBW'(t3_r);
        state_nxt = ST_CR_ACC;
      end
      ST_CR_ACC: begin
        acc_nxt   = acc_r + ACCW'(prod_r);
        state_nxt = ST_CR_RES;
      end
      ST_CR_RES: begin
        res_nxt[axis_r] = sat32((acc_r + ONE_A) >>> (FRAC_BITS + 1));
        axis_nxt        = axis_r + 2'd1;
        state_nxt       = (axis_r == 2'd2) ? ST_DONE : ST_CR_COEF;
      end
      // de Casteljau: one level after another, buffer entry i takes lerp(i, i+1)
      ST_BZ_R0: begin
        rd_addr   = '0;
        state_nxt = ST_BZ_R1;
      end
      ST_BZ_R1: begin
        prev_nxt  = src;
        rd_addr   = AW'(idx_r + NW'(1));
        state_nxt = ST_BZ_MUL;
      end
      ST_BZ_MUL: begin
        cur_nxt   = src;
        mul_a     = MUL_AW'(src) - MUL_AW'(prev_r);
        mul_b     = MBW'(t_r);
        state_nxt = ST_BZ_WR;
      end
      ST_BZ_WR: begin
        wm_we    = 1'b1;
        wm_data  = $signed(w);
        prev_nxt = cur_r;
        if (idx_r + NW'(2) == lvl_r) begin
          idx_nxt   = '0;
          state_nxt = ST_BZ_R0;
          if (lvl_r == NW'(2)) begin
            res_nxt[axis_r] = w;
            axis_nxt        = axis_r + 2'd1;
            lvl_nxt         = n_r;
            first_nxt       = 1'b1;
            if (axis_r == 2'd2) state_nxt = ST_DONE;
          end else begin
            lvl_nxt   = lvl_r - NW'(1);
            first_nxt = 1'b0;
          end
        end else begin
          idx_nxt   = idx_r + NW'(1);
          rd_addr   = AW'(idx_r + NW'(2));
          state_nxt = ST_BZ_MUL;
        end
      end
      ST_DONE: begin
        // hold the result until the output register is free
        if (!out_valid_r || out_ready) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      kind_r      <= KIND_LINEAR;
      count_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_CURVE_KIND:  kind_r  <= cfg_wdata[1:0];
          REG_POINT_COUNT: count_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    n_r      <= n_nxt;
    t_r      <= t_nxt;
    f_r      <= f_nxt;
    base_r   <= base_nxt;
    fa_r     <= fa_nxt;
    closed_r <= closed_nxt;
    axis_r   <= axis_nxt;
    j_r      <= j_nxt;
    lvl_r    <= lvl_nxt;
    idx_r    <= idx_nxt;
    first_r  <= first_nxt;
    prev_r   <= prev_nxt;
    cur_r    <= cur_nxt;
    wa_r     <= wa_nxt;
    pw_r     <= pw_nxt;
    d_r      <= d_nxt;
    t2_r     <= t2_nxt;
    t3_r     <= t3_nxt;
    c1_r     <= c1_nxt;
    c2_r     <= c2_nxt;
    c3_r     <= c3_nxt;
    acc_r    <= acc_nxt;
    res_r    <= res_nxt;
    prod_r   <= mul_a * mul_b;
    if (out_load) begin
      out_r.out_x <= $signed(res_r[0]);
      out_r.out_y <= $signed(res_r[1]);
      out_r.out_z <= $signed(res_r[2]);
    end
  end

  // Point store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (pm_we) begin
      pmem[AW'(in_data.slot)] <= {in_data.pos_z, in_data.pos_y, in_data.pos_x};
    end
    rdata_r <= pmem[rd_addr];
  end

  // Bezier working buffer: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wm_we) begin
      wmem[wm_addr] <= wm_data;
    end
    wdata_r <= wmem[rd_addr];
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef SYNTHESIS
  a_load_stays_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_data.op == OP_LOAD) |=> (state_r == ST_IDLE))
    else $error("load item left the sequencer busy");

  a_bz_level: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_BZ_MUL || state_r == ST_BZ_WR) |->
      (lvl_r >= NW'(2) && 32'(idx_r) + 2 <= 32'(lvl_r)))
    else $error("Bezier index beyond its level");

  a_done_posts: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && (!out_valid_r || out_ready)) |=>
      (out_valid_r && state_r == ST_IDLE))
    else $error("finished result not posted");
`endif

endmodule

>>> verif/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import spe_pkg::*;

  localparam longint ONE        = 64'sd1 << FRAC_BITS_DEF;
  localparam longint CLOSE_EPS  = (ONE + 50) / 100;
  localparam int     DRAIN_WAIT = 1200;   // margin for the longest Bezier run to finish
  localparam int     STALL_MAX  = 20000;  // cycles with no item accepted and no point taken
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  // Scoreboard: mirrors the point store and registers, predicts each evaluation
  class spline_scoreboard;
    longint    px[MAX_POINTS_DEF];
    longint    py[MAX_POINTS_DEF];
    longint    pz[MAX_POINTS_DEF];
    logic [1:0] kind;
    logic [4:0] count;
    out_item_t pending[$];
    int        errors;

    function new();
      kind   = KIND_LINEAR;
      count  = 0;
      errors = 0;
      for (int i = 0; i < MAX_POINTS_DEF; i++) begin
        px[i] = 0;
        py[i] = 0;
        pz[i] = 0;
      end
    endfunction

    function void set_reg(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] val);
      if (idx == REG_CURVE_KIND) kind = val[1:0];
      else if (idx == REG_POINT_COUNT) count = val;
    endfunction

    function longint coord(int axis, int i);
      if (axis == 0) return px[i];
      if (axis == 1) return py[i];
      return pz[i];
    endfunction

    function longint blend(longint p, longint q, longint f);
      return p + (((q - p) * f + ONE / 2) >>> FRAC_BITS_DEF);
    endfunction

    // Catmull-Rom list with one added point at each end
    function longint padded(int axis, int k, int n, bit closed);
      if (k == 0) return coord(axis, closed ? n - 2 : 0);
      if (k == n + 1) return coord(axis, closed ? 1 : n - 1);
      return coord(axis, k - 1);
    endfunction

    function longint curve_axis(int axis, int n, longint t, bit closed);
      longint seg_pos, f, w[MAX_POINTS_DEF];
      longint p0, p1, p2, p3, t2, t3, acc;
      int seg;
      seg_pos = t * (n - 1);
      seg = int'(seg_pos >>> FRAC_BITS_DEF);
      f = seg_pos & (ONE - 1);
      if (seg > n - 2) seg = n - 2;
      case (kind)
        KIND_LINEAR: begin
          if (t >= ONE) return coord(axis, n - 1);
          return blend(coord(axis, seg), coord(axis, seg + 1), f);
        end
        KIND_BEZIER: begin
          for (int i = 0; i < n; i++) w[i] = coord(axis, i);
          for (int m = n; m > 1; m--)
            for (int i = 0; i + 1 < m; i++) w[i] = blend(w[i], w[i + 1], t);
          return w[0];
        end
        KIND_CATMULL: begin
          if (t >= ONE) return coord(axis, n - 1);
          p0 = padded(axis, seg, n, closed);
          p1 = padded(axis, seg + 1, n, closed);
          p2 = padded(axis, seg + 2, n, closed);
          p3 = padded(axis, seg + 3, n, closed);
          t2 = (f * f) >>> FRAC_BITS_DEF;
          t3 = (t2 * f) >>> FRAC_BITS_DEF;
          acc = 2 * p1 * ONE + (p2 - p0) * f + (2 * p0 - 5 * p1 + 4 * p2 - p3) * t2
              + (3 * p1 - 3 * p2 + p3 - p0) * t3;
          return (acc + ONE) >>> (FRAC_BITS_DEF + 1);
        end
        default: return 0;
      endcase
    endfunction

    function logic signed [31:0] clip(longint v);
      if (v > 64'sd2147483647) return 32'sh7fffffff;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return v[31:0];
    endfunction

    function void note_input(in_item_t it);
      int n;
      longint t, dx, dy, dz, r[3];
      bit closed;
      out_item_t res;
      if (it.op == OP_LOAD) begin
        px[it.slot] = it.pos_x;
        py[it.slot] = it.pos_y;
        pz[it.slot] = it.pos_z;
        return;
      end
      n = (count > MAX_POINTS_DEF) ? MAX_POINTS_DEF : count;
      t = it.param_t;
      if (t < 0) t = 0;
      if (t > ONE) t = ONE;
      closed = 0;
      r[0] = 0; r[1] = 0; r[2] = 0;
      if (n == 1) begin
        r[0] = px[0]; r[1] = py[0]; r[2] = pz[0];
      end else if (n >= 2) begin
        dx = px[0] - px[n - 1]; if (dx < 0) dx = -dx;
        dy = py[0] - py[n - 1]; if (dy < 0) dy = -dy;
        dz = pz[0] - pz[n - 1]; if (dz < 0) dz = -dz;
        if (dx < CLOSE_EPS && dy < CLOSE_EPS && dz < CLOSE_EPS)
          closed = (dx * dx + dy * dy + dz * dz) < CLOSE_EPS * CLOSE_EPS;
        for (int a = 0; a < 3; a++) r[a] = curve_axis(a, n, t, closed);
      end
      res.out_x = clip(r[0]);
      res.out_y = clip(r[1]);
      res.out_z = clip(r[2]);
      pending = {pending, res};
    endfunction

    function void check_point(out_item_t got);
      out_item_t exp_pt;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected point x=%h y=%h z=%h",
                                   got.out_x, got.out_y, got.out_z);
        return;
      end
      exp_pt = pending.pop_front();
      if (got !== exp_pt) begin
        errors++;
        if (errors <= 10)
          $display("point mismatch: exp x=%h y=%h z=%h got x=%h y=%h z=%h",
                   exp_pt.out_x, exp_pt.out_y, exp_pt.out_z,
                   got.out_x, got.out_y, got.out_z);
      end
    endfunction
  endclass

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  in_item_t   in_data;
  logic       out_valid;
  logic       out_ready;
  out_item_t  out_data;
  logic       cfg_we;
  logic [CFG_IW-1:0] cfg_index;
  logic [CFG_DW-1:0] cfg_wdata;

  spline_point_evaluator DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  spline_scoreboard sb = new();
  bit quiet;        // set during the stretch where neither side idles
  int stall_cycles;

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // Hold out_ready low now and then to back up finished points
  always @(negedge clk) begin
    out_ready <= quiet ? 1'b1 : ($urandom_range(99) >= 9);
  end

  // Check every accepted point; watch for a stuck block
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) sb.check_point(out_data);
      if ((out_valid && out_ready) || (in_valid && in_ready)) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= STALL_MAX) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // Present one item, idling first at random; returns at the accepting edge
  task automatic send(in_item_t it);
    @(negedge clk);
    while (!quiet && $urandom_range(99) < 9) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    sb.note_input(it);
  endtask

  // Drop valid, let every expected point arrive and the sequencer settle
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
    sb.set_reg(idx, val);
  endtask

  task automatic load_pt(int slot, logic [31:0] x, logic [31:0] y, logic [31:0] z);
    in_item_t it;
    it = '{op: OP_LOAD, slot: slot[3:0], pos_x: x, pos_y: y, pos_z: z,
           param_t: $urandom()};
    send(it);
  endtask

  task automatic eval_at(logic [31:0] t);
    in_item_t it;
    it = '{op: OP_EVAL, slot: 4'($urandom()), pos_x: $urandom(), pos_y: $urandom(),
           pos_z: $urandom(), param_t: t};
    send(it);
  endtask

  // Mostly modest coordinates, sometimes full range or the extremes
  function automatic logic [31:0] pick_coord();
    case ($urandom_range(9))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2, 3: return $urandom();
      default: return $urandom_range(32'h00400000) - 32'h00200000;
    endcase
  endfunction

  function automatic logic [31:0] pick_param();
    case ($urandom_range(9))
      0: return 32'h0;
      1: return 32'h00010000;
      2: return $urandom();
      3: return 32'h80000000 | $urandom();
      default: return $urandom_range(32'h00010000);
    endcase
  endfunction

  initial begin
    logic [4:0] n_pick;
    logic [1:0] k_pick;
    int lim;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    out_ready = 1'b1;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    quiet     = 1'b0;
    stall_cycles = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Fill every slot so no unwritten entry is ever read
    for (int i = 0; i < MAX_POINTS_DEF; i++) begin
      if (i == 2) load_pt(i, 32'h7fffffff, 32'h80000000, 32'hffffffff);
      else if (i == 4) load_pt(i, 32'h80000000, 32'h7fffffff, 32'h0);
      else load_pt(i, pick_coord(), pick_coord(), pick_coord());
    end
    eval_at(32'h00008000);                 // no points in use: zero
    drain();
    write_reg(REG_POINT_COUNT, 5'd1);       // single point
    eval_at(32'h00004000);
    drain();
    write_reg(REG_CURVE_KIND, CFG_DW'(KIND_CATMULL));
    write_reg(REG_POINT_COUNT, 5'd4);
    load_pt(3, 32'(sb.px[0] + 3), 32'(sb.py[0] - 2), 32'(sb.pz[0]));  // closed path
    eval_at(32'h00004ccd);
    eval_at(32'h00010000);                  // end of curve
    eval_at(32'hfffb0000);                  // negative t clamps to zero
    drain();
    write_reg(REG_CURVE_KIND, CFG_DW'(KIND_BEZIER));
    write_reg(REG_POINT_COUNT, 5'd31);      // above capacity acts as full store
    eval_at(32'h7fffffff);
    drain();
    write_reg(REG_CURVE_KIND, CFG_DW'(KIND_UNUSED));  // unknown curve kind: zero
    write_reg(REG_POINT_COUNT, 5'd5);
    eval_at(32'h00008000);
    drain();

    // Random phases: a setting, then loads and evaluations mixed
    for (int ph = 0; ph < 10; ph++) begin
      k_pick = (ph < 4) ? ph[1:0] : 2'($urandom_range(3));
      case (ph)
        1: n_pick = 5'd16;
        5: n_pick = 5'd0;
        6: n_pick = 5'd2;
        default: n_pick = 5'($urandom_range(2, (k_pick == KIND_BEZIER) ? 8 : 16));
      endcase
      write_reg(REG_CURVE_KIND, CFG_DW'(k_pick));
      write_reg(REG_POINT_COUNT, n_pick);
      quiet = (ph == 3);
      lim = (n_pick > MAX_POINTS_DEF) ? MAX_POINTS_DEF : n_pick;
      for (int j = 0; j < 64; j++) begin
        if ($urandom_range(2) == 0) begin
          // Close the path now and then, within a few LSBs
          if (lim >= 2 && $urandom_range(3) == 0)
            load_pt(lim - 1, 32'(sb.px[0] + longint'($urandom_range(8)) - 4),
                    32'(sb.py[0] + longint'($urandom_range(8)) - 4), 32'(sb.pz[0]));
          else
            load_pt($urandom_range(15), pick_coord(), pick_coord(), pick_coord());
        end else begin
          eval_at(pick_param());
        end
      end
      drain();
    end
    quiet = 1'b0;

    if (sb.errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
